// File: src/bale_pkg.sv
// ---------------------------------------------------------------------------
// Bounded array list engine package
// Operation and status codes, list sizing and the controller state type.
// ---------------------------------------------------------------------------
package bale_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DATA_W   = 32;

    // List sizing: entry count, entry index and count widths.
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned CNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 3'd0,
        OP_FIND    = 3'd1,
        OP_INSERT  = 3'd2,
        OP_SORTED  = 3'd3,
        OP_DELETE  = 3'd4,
        OP_REVERSE = 3'd5,
        OP_NOP6    = 3'd6,
        OP_NOP7    = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ_ISSUE,
        S_READ_WAIT,
        S_SEARCH_ISSUE,
        S_SEARCH_WAIT,
        S_SHUP_ISSUE,
        S_SHUP_WAIT,
        S_SHDN_ISSUE,
        S_SHDN_WAIT,
        S_SHDN_WRITE,
        S_REV_ISSUE,
        S_REV_WAIT,
        S_REV_WRITE,
        S_DONE,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture request fields
        logic rd_i;        // read memory at index i
        logic rd_j;        // read memory at index j (reverse partner)
        logic init_search; // i <= 0
        logic init_shup;   // i <= count (top of upward shift)
        logic init_shdn;   // i <= position
        logic init_rev;    // i <= 0, j <= count-1
        logic step_up;     // i <= i + 1
        logic step_down;   // i <= i - 1
        logic wr_shift;    // mem[i] <= read data (shift move)
        logic wr_val;      // mem[i] <= value, count++
        logic wr_rev_a;    // mem[i] <= read data (word from j)
        logic wr_rev_b;    // mem[j] <= read data (old word from i)
        logic rev_step;    // i++, j--
        logic cnt_dec;     // count--
        logic set_at;      // insert point <= i
        logic cap_data;    // data result <= read data
        logic cap_found;   // found index <= i
        logic set_status;
        t_status status;
        logic out_valid;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic pos_lt_cnt;  // position < count
        logic pos_gt_cnt;  // position > count
        logic full;        // count == capacity
        logic i_lt_cnt;    // i < count
        logic i_gt_at;     // i > insert point
        logic i1_lt_cnt;   // i + 1 < count
        logic i_lt_j;      // reverse not yet met
        logic match;       // read data equals value
        logic le;          // value <= read data (signed)
    } t_stat;

endpackage

// File: src/bale_datapath.sv
// ---------------------------------------------------------------------------
// Bounded array list datapath
// Entry memory, walk indexes, count and result registers.
// ---------------------------------------------------------------------------
module bale_datapath
    import bale_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [4:0]               i_position,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [IDX_W-1:0]         o_found_index,
    output logic [CNT_W-1:0]         o_count
);

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd;
    logic [CNT_W-1:0]  r_i, r_j, r_at, r_cnt;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [4:0]        r_pos;
    logic [STATUS_W-1:0] r_status;
    logic [DATA_W-1:0]   r_data;
    logic [IDX_W-1:0]    r_fidx;
    logic [CNT_W-1:0]  w_addr, w_ridx;

    // Memory read address selection and write address.
    assign w_ridx = i_cmd.rd_j ? r_j : (i_cmd.rd_i ? r_i : r_i - CNT_W'(1));
    assign w_addr = i_cmd.wr_rev_b ? r_j : r_i;

    // Entry memory: one write and one registered read per cycle. A read and a
    // write of the same entry in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_ridx[IDX_W-1:0]];
        if (i_cmd.wr_shift || i_cmd.wr_rev_a || i_cmd.wr_rev_b) begin
            r_mem[w_addr[IDX_W-1:0]] <= r_rd;
        end else if (i_cmd.wr_val) begin
            r_mem[w_addr[IDX_W-1:0]] <= r_val;
        end
    end

    // Request capture, walk indexes and results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= i_value;
            r_pos <= i_position;
            r_data <= '0;
            r_fidx <= '0;
        end
        if (i_cmd.init_search || i_cmd.init_rev) begin
            r_i <= '0;
        end else if (i_cmd.init_shup) begin
            r_i <= r_cnt;
        end else if (i_cmd.init_shdn) begin
            r_i <= CNT_W'(r_pos);
        end else if (i_cmd.step_up || i_cmd.rev_step) begin
            r_i <= r_i + CNT_W'(1);
        end else if (i_cmd.step_down) begin
            r_i <= r_i - CNT_W'(1);
        end
        if (i_cmd.init_rev) begin
            r_j <= r_cnt - CNT_W'(1);
        end else if (i_cmd.rev_step) begin
            r_j <= r_j - CNT_W'(1);
        end
        if (i_cmd.set_at) begin
            r_at <= r_i;
        end else if (i_cmd.init_shup && r_op == OP_INSERT) begin
            r_at <= CNT_W'(r_pos);
        end
        if (i_cmd.cap_data) begin
            r_data <= r_rd;
        end
        if (i_cmd.cap_found) begin
            r_fidx <= r_i[IDX_W-1:0];
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.wr_val) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Status flags for the controller.
    always_comb begin
        o_stat.op         = t_op'(r_op);
        o_stat.pos_lt_cnt = CNT_W'(r_pos) < r_cnt && r_pos <= 5'(CAPACITY);
        o_stat.pos_gt_cnt = {{CNT_W{1'b0}}, r_pos} > {5'd0, r_cnt};
        o_stat.full       = r_cnt >= CNT_W'(CAPACITY);
        o_stat.i_lt_cnt   = r_i < r_cnt;
        o_stat.i_gt_at    = r_i > r_at;
        o_stat.i1_lt_cnt  = (r_i + CNT_W'(1)) < r_cnt;
        o_stat.i_lt_j     = r_i < r_j && r_cnt > CNT_W'(1);
        o_stat.match      = r_rd == r_val;
        o_stat.le         = $signed(r_val) <= $signed(r_rd);
    end

    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found_index = r_fidx;
    assign o_count       = r_cnt;

endmodule

// File: src/bale_ctrl.sv
// ---------------------------------------------------------------------------
// Bounded array list controller
// Sequences each request through checks, walks and the result transaction.
// ---------------------------------------------------------------------------
module bale_ctrl
    import bale_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                case (i_stat.op)
                    OP_READ:   n_state = i_stat.pos_lt_cnt ? S_READ_ISSUE : S_OUT;
                    OP_FIND:   n_state = S_SEARCH_ISSUE;
                    OP_INSERT: n_state = (i_stat.pos_gt_cnt || i_stat.full) ? S_OUT
                                                                            : S_SHUP_ISSUE;
                    OP_SORTED: n_state = i_stat.full ? S_OUT : S_SEARCH_ISSUE;
                    OP_DELETE: n_state = i_stat.pos_lt_cnt ? S_SHDN_ISSUE : S_OUT;
                    OP_REVERSE: n_state = S_REV_ISSUE;
                    default:   n_state = S_OUT;
                endcase
            end
            S_READ_ISSUE: n_state = S_READ_WAIT;
            S_READ_WAIT:  n_state = S_OUT;
            S_SEARCH_ISSUE: n_state = i_stat.i_lt_cnt ? S_SEARCH_WAIT
                                     : (i_stat.op == OP_SORTED ? S_SHUP_ISSUE : S_OUT);
            S_SEARCH_WAIT: begin
                if (i_stat.op == OP_FIND) begin
                    n_state = i_stat.match ? S_OUT : S_SEARCH_ISSUE;
                end else begin
                    n_state = i_stat.le ? S_SHUP_ISSUE : S_SEARCH_ISSUE;
                end
            end
            S_SHUP_ISSUE: n_state = i_stat.i_gt_at ? S_SHUP_WAIT : S_DONE;
            S_SHUP_WAIT:  n_state = S_SHUP_ISSUE;
            S_SHDN_ISSUE: n_state = i_stat.i1_lt_cnt ? S_SHDN_WAIT : S_DONE;
            S_SHDN_WAIT:  n_state = S_SHDN_WRITE;
            S_SHDN_WRITE: n_state = S_SHDN_ISSUE;
            S_REV_ISSUE:  n_state = i_stat.i_lt_j ? S_REV_WAIT : S_OUT;
            S_REV_WAIT:   n_state = S_REV_WRITE;
            S_REV_WRITE:  n_state = S_REV_ISSUE;
            S_DONE:       n_state = S_OUT;
            S_OUT:        if (i_out_ready) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.set_status = 1'b1;
                o_cmd.init_search = 1'b1;
                case (i_stat.op)
                    OP_READ: begin
                        o_cmd.init_search = 1'b0;
                        o_cmd.init_shdn = 1'b1;
                        o_cmd.status = i_stat.pos_lt_cnt ? ST_OK : ST_BAD_POS;
                    end
                    OP_FIND: o_cmd.status = ST_NOT_FOUND;
                    OP_INSERT: begin
                        o_cmd.init_search = 1'b0;
                        o_cmd.status = i_stat.pos_gt_cnt ? ST_BAD_POS
                                     : (i_stat.full ? ST_FULL : ST_OK);
                        o_cmd.init_shup = 1'b1;
                    end
                    OP_SORTED: o_cmd.status = i_stat.full ? ST_FULL : ST_OK;
                    OP_DELETE: begin
                        o_cmd.init_search = 1'b0;
                        o_cmd.init_shdn = 1'b1;
                        o_cmd.status = i_stat.pos_lt_cnt ? ST_OK : ST_BAD_POS;
                    end
                    OP_REVERSE: begin
                        o_cmd.init_search = 1'b0;
                        o_cmd.init_rev = 1'b1;
                    end
                    default: o_cmd.status = ST_OK;
                endcase
            end
            S_READ_ISSUE: o_cmd.rd_i = 1'b1;
            S_READ_WAIT:  o_cmd.cap_data = 1'b1;
            S_SEARCH_ISSUE: begin
                o_cmd.rd_i = 1'b1;
                if (!i_stat.i_lt_cnt && i_stat.op == OP_SORTED) begin
                    o_cmd.set_at = 1'b1;
                    o_cmd.init_shup = 1'b1;
                end
            end
            S_SEARCH_WAIT: begin
                if (i_stat.op == OP_FIND) begin
                    if (i_stat.match) begin
                        o_cmd.cap_found = 1'b1;
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_OK;
                    end else begin
                        o_cmd.step_up = 1'b1;
                    end
                end else if (i_stat.le) begin
                    o_cmd.set_at = 1'b1;
                    o_cmd.init_shup = 1'b1;
                end else begin
                    o_cmd.step_up = 1'b1;
                end
            end
            // Read mem[i-1] when above the insert point, otherwise write the value.
            S_SHUP_ISSUE: begin
                if (!i_stat.i_gt_at) begin
                    o_cmd.wr_val = 1'b1;
                end
            end
            S_SHUP_WAIT: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.step_down = 1'b1;
            end
            // Step to the next entry, read it while stepping back, then write it
            // into the slot below.
            S_SHDN_ISSUE: begin
                if (i_stat.i1_lt_cnt) begin
                    o_cmd.step_up = 1'b1;
                    o_cmd.rd_i = 1'b0;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_SHDN_WAIT: begin
                o_cmd.rd_i = 1'b1;
                o_cmd.step_down = 1'b1;
            end
            S_SHDN_WRITE: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.step_up = 1'b1;
            end
            // Read mem[j], then write it at i while reading the old word at i,
            // then write that word at j.
            S_REV_ISSUE: o_cmd.rd_j = i_stat.i_lt_j;
            S_REV_WAIT: begin
                o_cmd.rd_i = 1'b1;
                o_cmd.wr_rev_a = 1'b1;
            end
            S_REV_WRITE: begin
                o_cmd.wr_rev_b = 1'b1;
                o_cmd.rev_step = 1'b1;
            end
            S_OUT: o_cmd.out_valid = 1'b1;
            default: o_cmd.out_valid = 1'b0;
        endcase
    end

endmodule

// File: src/bounded_array_list_engine_core.sv
// ---------------------------------------------------------------------------
// Bounded array list engine core
// Ordered list of signed words with read, find, insert, sorted insert,
// delete and reverse requests.
// ---------------------------------------------------------------------------
// One request is taken at a time and answered with one result transaction;
// the input is not ready again until that result has been accepted. The
// entry memory gives one registered read and one write per cycle, so the
// list is walked one entry at a time. A request is accepted and then
// checked, and the result is offered after the walk ends. A read issues
// one memory read and captures the word; find and the search of a sorted
// insert read and compare each entry looked at, an insert reads and
// writes each entry moved up, a delete steps, reads and writes each entry
// moved down and a reverse reads and writes both words of each pair. The
// longest request is a delete at the head of a full list.
module bounded_array_list_engine_core
    import bale_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [4:0]               i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [3:0]               o_found_index,
    output logic [4:0]               o_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bale_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_found_index(o_found_index),
        .o_count      (o_count)
    );

    assign o_out_valid = w_cmd.out_valid;

    // A result is never offered while a request is being accepted.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and result overlap");

    // The count never exceeds capacity.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_count <= 5'(CAPACITY)) else $error("count overflow");

endmodule
